/* src/geic_pkg.sv */
package geic_pkg;

  // line and port counts
  localparam int NUM_LINES = 16;
  localparam int NUM_PORTS = 11;

  // field widths
  localparam int LINE_W    = 16;
  localparam int SEL_W     = 8;
  localparam int OFF_W     = 6;
  localparam int DATA_W    = 32;
  localparam int PORT_W    = 4;
  localparam int IRQ_W     = 7;
  localparam int PORT_CMP_W = PORT_W + 1;

  // item kinds carried on tuser
  typedef enum logic [1:0] {
    ACT_READ   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_SAMPLE = 2'd2
  } action_e;

  // register word offsets
  localparam logic [OFF_W-1:0] OFF_RISE_EN   = 6'd0;
  localparam logic [OFF_W-1:0] OFF_FALL_EN   = 6'd1;
  localparam logic [OFF_W-1:0] OFF_RISE_PEND = 6'd3;
  localparam logic [OFF_W-1:0] OFF_FALL_PEND = 6'd4;
  localparam logic [OFF_W-1:0] OFF_PORT_SEL  = 6'd24;
  localparam logic [OFF_W-1:0] OFF_IRQ_MASK  = 6'd32;
  localparam logic [OFF_W-1:0] OFF_EVT_MASK  = 6'd33;

  // one input item
  typedef struct packed {
    action_e             action;
    logic [OFF_W-1:0]    reg_offset;
    logic [DATA_W-1:0]   write_data;
    logic [PORT_W-1:0]   port_index;
    logic [LINE_W-1:0]   port_levels;
  } item_t;

  // one result item
  typedef struct packed {
    logic [LINE_W-1:0] event_pulses;
    logic [IRQ_W-1:0]  irq_lines;
    logic [DATA_W-1:0] read_data;
  } result_t;

endpackage

/* src/geic_core.sv */
module geic_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  geic_pkg::item_t   item_i,
  output geic_pkg::result_t res_o
);

  logic [geic_pkg::LINE_W-1:0] rise_en_q, rise_en_d;
  logic [geic_pkg::LINE_W-1:0] fall_en_q, fall_en_d;
  logic [geic_pkg::LINE_W-1:0] rise_pend_q, rise_pend_d;
  logic [geic_pkg::LINE_W-1:0] fall_pend_q, fall_pend_d;
  logic [geic_pkg::LINE_W-1:0] irq_mask_q, irq_mask_d;
  logic [geic_pkg::LINE_W-1:0] evt_mask_q, evt_mask_d;
  logic [geic_pkg::LINE_W-1:0] prev_q, prev_d;
  logic [geic_pkg::SEL_W-1:0]  line_port_q [geic_pkg::NUM_LINES];
  logic [geic_pkg::SEL_W-1:0]  line_port_d [geic_pkg::NUM_LINES];

  logic                        is_read, is_write, is_sample, port_ok, sel_word;
  logic [geic_pkg::LINE_W-1:0] wr_low, line_hit, rise_hit, fall_hit, active;
  logic [geic_pkg::DATA_W-1:0] rdata;

  // item decode
  assign is_read   = (item_i.action == geic_pkg::ACT_READ);
  assign is_write  = (item_i.action == geic_pkg::ACT_WRITE);
  assign is_sample = (item_i.action == geic_pkg::ACT_SAMPLE);
  assign port_ok   = ({1'b0, item_i.port_index} <
                      geic_pkg::PORT_CMP_W'(geic_pkg::NUM_PORTS));
  assign sel_word  = (item_i.reg_offset[geic_pkg::OFF_W-1:2] ==
                      geic_pkg::OFF_PORT_SEL[geic_pkg::OFF_W-1:2]);
  assign wr_low    = item_i.write_data[geic_pkg::LINE_W-1:0];

  // per-line edge detection for lines mapped to the sampled port
  always_comb begin
    for (int i = 0; i < geic_pkg::NUM_LINES; i++) begin
      line_hit[i] = is_sample && port_ok &&
                    (line_port_q[i] == {4'b0, item_i.port_index});
      rise_hit[i] = line_hit[i] && item_i.port_levels[i] && !prev_q[i] && rise_en_q[i];
      fall_hit[i] = line_hit[i] && !item_i.port_levels[i] && prev_q[i] && fall_en_q[i];
      prev_d[i]   = line_hit[i] ? item_i.port_levels[i] : prev_q[i];
    end
  end

  // register writes and pending updates
  always_comb begin
    rise_en_d   = rise_en_q;
    fall_en_d   = fall_en_q;
    irq_mask_d  = irq_mask_q;
    evt_mask_d  = evt_mask_q;
    rise_pend_d = rise_pend_q | rise_hit;
    fall_pend_d = fall_pend_q | fall_hit;
    for (int i = 0; i < geic_pkg::NUM_LINES; i++) begin
      line_port_d[i] = line_port_q[i];
    end
    if (is_write) begin
      case (item_i.reg_offset)
        geic_pkg::OFF_RISE_EN:   rise_en_d   = wr_low;
        geic_pkg::OFF_FALL_EN:   fall_en_d   = wr_low;
        geic_pkg::OFF_RISE_PEND: rise_pend_d = rise_pend_q & ~wr_low;
        geic_pkg::OFF_FALL_PEND: fall_pend_d = fall_pend_q & ~wr_low;
        geic_pkg::OFF_IRQ_MASK:  irq_mask_d  = wr_low;
        geic_pkg::OFF_EVT_MASK:  evt_mask_d  = wr_low;
        default: begin
          if (sel_word) begin
            for (int k = 0; k < 4; k++) begin
              line_port_d[{item_i.reg_offset[1:0], 2'(k)}] =
                item_i.write_data[k*geic_pkg::SEL_W +: geic_pkg::SEL_W];
            end
          end
        end
      endcase
    end
  end

  // bus read mux
  always_comb begin
    rdata = '0;
    if (is_read) begin
      case (item_i.reg_offset)
        geic_pkg::OFF_RISE_EN:   rdata = {16'b0, rise_en_q};
        geic_pkg::OFF_FALL_EN:   rdata = {16'b0, fall_en_q};
        geic_pkg::OFF_RISE_PEND: rdata = {16'b0, rise_pend_q};
        geic_pkg::OFF_FALL_PEND: rdata = {16'b0, fall_pend_q};
        geic_pkg::OFF_IRQ_MASK:  rdata = {16'b0, irq_mask_q};
        geic_pkg::OFF_EVT_MASK:  rdata = {16'b0, evt_mask_q};
        default: begin
          if (sel_word) begin
            for (int k = 0; k < 4; k++) begin
              rdata[k*geic_pkg::SEL_W +: geic_pkg::SEL_W] =
                line_port_q[{item_i.reg_offset[1:0], 2'(k)}];
            end
          end
        end
      endcase
    end
  end

  // result, interrupts taken from the updated state
  assign active = (rise_pend_d | fall_pend_d) & irq_mask_d;

  always_comb begin
    res_o.read_data    = rdata;
    res_o.irq_lines    = {|active[15:10], |active[9:5], active[4:0]};
    res_o.event_pulses = (rise_hit | fall_hit) & evt_mask_q;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_en_q   <= '0;
      fall_en_q   <= '0;
      rise_pend_q <= '0;
      fall_pend_q <= '0;
      irq_mask_q  <= '0;
      evt_mask_q  <= '0;
      prev_q      <= '0;
      for (int i = 0; i < geic_pkg::NUM_LINES; i++) begin
        line_port_q[i] <= '0;
      end
    end else if (accept_i) begin
      rise_en_q   <= rise_en_d;
      fall_en_q   <= fall_en_d;
      rise_pend_q <= rise_pend_d;
      fall_pend_q <= fall_pend_d;
      irq_mask_q  <= irq_mask_d;
      evt_mask_q  <= evt_mask_d;
      prev_q      <= prev_d;
      for (int i = 0; i < geic_pkg::NUM_LINES; i++) begin
        line_port_q[i] <= line_port_d[i];
      end
    end
  end

endmodule

/* src/gpio_edge_interrupt_controller.sv */
// External interrupt edge controller for 16 GPIO lines. Each input item is a
// bus read, a bus write (tuser selects the kind) or one sample of a port's 16
// pin levels; each item gives exactly one result item holding read data, the
// seven interrupt lines (pending AND mask, after this item's update) and the
// per-line event pulses. The block takes one item per clock: all 16 lines are
// handled in parallel in one pass of logic from the accepted item into the
// result register, so a result is valid in the cycle after its item is accepted,
// and a stalled result only holds off new items while it is still not taken.
module gpio_edge_interrupt_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // reg_offset[5:0], write_data[37:6], port_index[41:38], port_levels[57:42],
  // zero fill [63:58]
  input  logic [63:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data[31:0], irq_lines[38:32], event_pulses[54:39], zero fill [55]
  output logic [55:0] m_axis_tdata
);

  geic_pkg::item_t   item;
  geic_pkg::result_t res, res_q;
  logic              in_acc, out_valid_q, out_valid_d;

  // unpack the input item
  always_comb begin
    item.action      = geic_pkg::action_e'(s_axis_tuser);
    item.reg_offset  = s_axis_tdata[5:0];
    item.write_data  = s_axis_tdata[37:6];
    item.port_index  = s_axis_tdata[41:38];
    item.port_levels = s_axis_tdata[57:42];
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  geic_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_acc),
    .item_i   (item),
    .res_o    (res)
  );

  // result register
  assign out_valid_d = in_acc || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, res_q.event_pulses, res_q.irq_lines, res_q.read_data};

  // every accepted item shows up as a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> m_axis_tvalid)
    else $error("accepted item gave no result");

  // an empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty result register");

  // only samples produce event pulses
  a_events_from_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && item.action != geic_pkg::ACT_SAMPLE) |=> (res_q.event_pulses == '0))
    else $error("event pulse on a bus item");

  // only reads return data
  a_data_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && item.action != geic_pkg::ACT_READ) |=> (res_q.read_data == '0))
    else $error("read data on a non-read item");

endmodule

/* dv/gpio_edge_interrupt_controller_checker.sv */
module gpio_edge_interrupt_controller_checker
  import geic_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // reg_offset[5:0], write_data[37:6], port_index[41:38], port_levels[57:42],
  // zero fill [63:58]
  input  logic [63:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data[31:0], irq_lines[38:32], event_pulses[54:39], zero fill [55]
  input  logic [55:0] m_axis_tdata,
  output int          fail_count_o,
  output int          outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the controller registers
  logic [LINE_W-1:0] en_rise;
  logic [LINE_W-1:0] en_fall;
  logic [LINE_W-1:0] pend_rise;
  logic [LINE_W-1:0] pend_fall;
  logic [LINE_W-1:0] mask_irq;
  logic [LINE_W-1:0] mask_evt;
  logic [SEL_W-1:0]  port_of_line [NUM_LINES];
  logic [LINE_W-1:0] level_seen;

  // results still owed by the block, oldest first
  result_t exti_out_q [$];
  result_t got_res;
  result_t want_res;
  result_t new_res;
  int      errors;

  assign fail_count_o = errors;

  // one line per mismatch
  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic logic is_sel_word(input logic [OFF_W-1:0] off);
    return int'(off) >= int'(OFF_PORT_SEL) && int'(off) <= int'(OFF_PORT_SEL) + 3;
  endfunction

  // advance the shadow state by one item and work out its result
  task automatic exti_step(input logic [1:0] act, input logic [OFF_W-1:0] off,
                           input logic [DATA_W-1:0] wdat,
                           input logic [PORT_W-1:0] port,
                           input logic [LINE_W-1:0] lvl, output result_t res);
    int               base;
    logic             hit;
    logic             now;
    logic             was;
    logic [LINE_W-1:0] active;
    res = '0;
    base = (int'(off) - int'(OFF_PORT_SEL)) * 4;
    if (act == ACT_READ) begin
      case (off)
        OFF_RISE_EN:   res.read_data = {16'b0, en_rise};
        OFF_FALL_EN:   res.read_data = {16'b0, en_fall};
        OFF_RISE_PEND: res.read_data = {16'b0, pend_rise};
        OFF_FALL_PEND: res.read_data = {16'b0, pend_fall};
        OFF_IRQ_MASK:  res.read_data = {16'b0, mask_irq};
        OFF_EVT_MASK:  res.read_data = {16'b0, mask_evt};
        default: begin
          if (is_sel_word(off)) begin
            for (int k = 0; k < 4; k++) res.read_data[8*k +: 8] = port_of_line[base + k];
          end
        end
      endcase
    end else if (act == ACT_WRITE) begin
      case (off)
        OFF_RISE_EN:   en_rise = wdat[15:0];
        OFF_FALL_EN:   en_fall = wdat[15:0];
        OFF_RISE_PEND: pend_rise &= ~wdat[15:0];
        OFF_FALL_PEND: pend_fall &= ~wdat[15:0];
        OFF_IRQ_MASK:  mask_irq = wdat[15:0];
        OFF_EVT_MASK:  mask_evt = wdat[15:0];
        default: begin
          if (is_sel_word(off)) begin
            for (int k = 0; k < 4; k++) port_of_line[base + k] = wdat[8*k +: 8];
          end
        end
      endcase
    end else if (act == ACT_SAMPLE && int'(port) < NUM_PORTS) begin
      // only lines routed to the sampled port see it
      for (int i = 0; i < NUM_LINES; i++) begin
        if (port_of_line[i] == {4'b0, port}) begin
          now = lvl[i];
          was = level_seen[i];
          hit = 1'b0;
          if (now && !was && en_rise[i]) begin
            pend_rise[i] = 1'b1;
            hit = 1'b1;
          end
          if (!now && was && en_fall[i]) begin
            pend_fall[i] = 1'b1;
            hit = 1'b1;
          end
          if (hit && mask_evt[i]) res.event_pulses[i] = 1'b1;
          level_seen[i] = now;
        end
      end
    end
    // interrupt outputs after this item's update
    active = (pend_rise | pend_fall) & mask_irq;
    res.irq_lines = {|active[15:10], |active[9:5], active[4:0]};
  endtask

  // watch both channels, new items first so a short path still lines up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_rise    = '0;
      en_fall    = '0;
      pend_rise  = '0;
      pend_fall  = '0;
      mask_irq   = '0;
      mask_evt   = '0;
      level_seen = '0;
      for (int i = 0; i < NUM_LINES; i++) port_of_line[i] = '0;
      exti_out_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        exti_step(s_axis_tuser, s_axis_tdata[5:0], s_axis_tdata[37:6],
                  s_axis_tdata[41:38], s_axis_tdata[57:42], new_res);
        exti_out_q.push_back(new_res);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_res.read_data    = m_axis_tdata[31:0];
        got_res.irq_lines    = m_axis_tdata[38:32];
        got_res.event_pulses = m_axis_tdata[54:39];
        if (exti_out_q.size() == 0) begin
          flag_mismatch("result with nothing owed", m_axis_tdata[31:0], '0);
        end else begin
          want_res = exti_out_q.pop_front();
          if (got_res.read_data !== want_res.read_data)
            flag_mismatch("read_data", got_res.read_data, want_res.read_data);
          if (got_res.irq_lines !== want_res.irq_lines)
            flag_mismatch("irq_lines", 32'(got_res.irq_lines), 32'(want_res.irq_lines));
          if (got_res.event_pulses !== want_res.event_pulses)
            flag_mismatch("event_pulses", 32'(got_res.event_pulses),
                          32'(want_res.event_pulses));
        end
      end
    end
    outstanding_o = exti_out_q.size();
  end

endmodule

/* dv/gpio_edge_interrupt_controller_tb.sv */
module gpio_edge_interrupt_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import geic_pkg::*;

  // tuser code the block does not define
  localparam logic [1:0] ACT_SPARE = 2'd3;
  // software trigger word, not present in the block
  localparam logic [OFF_W-1:0] OFF_SW_TRIG = 6'd2;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // reg_offset[5:0], write_data[37:6], port_index[41:38], port_levels[57:42],
  // zero fill [63:58]
  logic [63:0] s_axis_tdata = '0;
  // action[1:0]
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // read_data[31:0], irq_lines[38:32], event_pulses[54:39], zero fill [55]
  logic [55:0] m_axis_tdata;

  int   fail_count;
  int   outstanding;
  logic gapless = 1'b0;
  logic rx_hold_req = 1'b0;

  gpio_edge_interrupt_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  gpio_edge_interrupt_controller_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end

  // offer one item and hold it until taken; entered and left at a falling edge
  task automatic send_item(input logic [1:0] act, input logic [OFF_W-1:0] off,
                           input logic [DATA_W-1:0] wdat,
                           input logic [PORT_W-1:0] port,
                           input logic [LINE_W-1:0] lvl);
    int gap;
    gap = gapless ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tuser  = act;
    s_axis_tdata  = {6'b0, lvl, port, wdat, off};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // mostly the mapped registers, now and then any offset
  function automatic logic [OFF_W-1:0] pick_offset();
    case ($urandom_range(0, 11))
      0:       return OFF_RISE_EN;
      1:       return OFF_FALL_EN;
      2:       return OFF_RISE_PEND;
      3:       return OFF_FALL_PEND;
      4, 5:    return OFF_PORT_SEL + OFF_W'($urandom_range(0, 3));
      6:       return OFF_IRQ_MASK;
      7:       return OFF_EVT_MASK;
      8:       return OFF_W'($urandom_range(0, 63));
      default: return OFF_PORT_SEL + OFF_W'($urandom_range(0, 3));
    endcase
  endfunction

  // result side: random stalls, one long hold-off on request
  initial begin
    int rx_gap;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_gap = 80;
      end else begin
        rx_gap = gapless ? 0 : $urandom_range(0, 12);
      end
      if (rx_gap > 0) begin
        m_axis_tready = 1'b0;
        repeat (rx_gap) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  // stimulus
  initial begin
    logic [LINE_W-1:0] pin_state [16];
    logic [PORT_W-1:0] port;
    logic [LINE_W-1:0] lvl;
    logic [OFF_W-1:0]  off;
    logic [DATA_W-1:0] wdat;
    int                pick;
    int                wait_cnt;
    for (int p = 0; p < 16; p++) pin_state[p] = '0;

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset values and unmapped reads
    send_item(ACT_READ, OFF_RISE_EN, $urandom(), $urandom(), $urandom());
    send_item(ACT_READ, OFF_SW_TRIG, $urandom(), $urandom(), $urandom());
    send_item(ACT_READ, 6'd63, $urandom(), $urandom(), $urandom());
    // enable both edges and all interrupts, events on lines 0 and 4; upper data bits must be dropped
    send_item(ACT_WRITE, OFF_RISE_EN, 32'hffff_ffff, $urandom(), $urandom());
    send_item(ACT_WRITE, OFF_FALL_EN, 32'h0000_ffff, $urandom(), $urandom());
    send_item(ACT_WRITE, OFF_IRQ_MASK, 32'hffff_ffff, $urandom(), $urandom());
    send_item(ACT_WRITE, OFF_EVT_MASK, 32'h0000_0011, $urandom(), $urandom());
    // first sample: high pins count as rising, then all fall
    send_item(ACT_SAMPLE, $urandom(), $urandom(), 4'd0, 16'hffff);
    send_item(ACT_SAMPLE, $urandom(), $urandom(), 4'd0, 16'h0000);
    send_item(ACT_READ, OFF_RISE_PEND, $urandom(), $urandom(), $urandom());
    send_item(ACT_READ, OFF_FALL_PEND, $urandom(), $urandom(), $urandom());
    // write one to clear pending
    send_item(ACT_WRITE, OFF_RISE_PEND, 32'h0000_0001, $urandom(), $urandom());
    send_item(ACT_WRITE, OFF_FALL_PEND, 32'hffff_ffff, $urandom(), $urandom());
    // remap lines 0-3, two of them to ports that do not exist
    send_item(ACT_WRITE, OFF_PORT_SEL, 32'hff0a_0b01, $urandom(), $urandom());
    send_item(ACT_READ, OFF_PORT_SEL, $urandom(), $urandom(), $urandom());
    send_item(ACT_SAMPLE, $urandom(), $urandom(), 4'd1, 16'hffff);
    send_item(ACT_SAMPLE, $urandom(), $urandom(), 4'd15, 16'h0000);
    send_item(ACT_SAMPLE, $urandom(), $urandom(), 4'd10, 16'h0004);
    // software trigger word is not there, unused tuser code
    send_item(ACT_WRITE, OFF_SW_TRIG, 32'hffff_ffff, $urandom(), $urandom());
    send_item(ACT_SPARE, $urandom(), $urandom(), $urandom(), $urandom());
    // rising edge disabled, level still tracked
    send_item(ACT_WRITE, OFF_RISE_EN, 32'h0000_0000, $urandom(), $urandom());
    send_item(ACT_SAMPLE, $urandom(), $urandom(), 4'd1, 16'h0000);
    send_item(ACT_SAMPLE, $urandom(), $urandom(), 4'd1, 16'h0001);
    send_item(ACT_WRITE, OFF_EVT_MASK, 32'hffff_ffff, $urandom(), $urandom());
    send_item(ACT_WRITE, OFF_PORT_SEL + 6'd3, 32'hffff_ffff, $urandom(), $urandom());
    send_item(ACT_READ, OFF_PORT_SEL + 6'd3, $urandom(), $urandom(), $urandom());

    // random traffic, half of it pin samples, mostly on a few busy ports
    for (int n = 0; n < 1300; n++) begin
      if (n % 150 == 0) gapless = ($urandom_range(0, 2) == 0);
      if (n == 400) begin
        gapless = 1'b1;
        rx_hold_req = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        case ($urandom_range(0, 9))
          0:       port = PORT_W'($urandom_range(NUM_PORTS, 15));
          1, 2, 3: port = PORT_W'($urandom_range(0, NUM_PORTS - 1));
          default: port = PORT_W'($urandom_range(0, 3));
        endcase
        if ($urandom_range(0, 2) == 0) lvl = LINE_W'($urandom());
        else lvl = pin_state[port] ^ (16'h1 << $urandom_range(0, 15));
        pin_state[port] = lvl;
        send_item(ACT_SAMPLE, $urandom(), $urandom(), port, lvl);
      end else if (pick < 65) begin
        send_item(ACT_READ, pick_offset(), $urandom(), $urandom(), $urandom());
      end else if (pick < 95) begin
        off = pick_offset();
        wdat = $urandom();
        // port selects mostly land on the busy ports
        if (int'(off) >= int'(OFF_PORT_SEL) && int'(off) <= int'(OFF_PORT_SEL) + 3) begin
          for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 9))
              9:       wdat[8*k +: 8] = 8'($urandom_range(0, 255));
              7, 8:    wdat[8*k +: 8] = 8'($urandom_range(0, NUM_PORTS - 1));
              default: wdat[8*k +: 8] = 8'($urandom_range(0, 3));
            endcase
          end
        end
        send_item(ACT_WRITE, off, wdat, $urandom(), $urandom());
      end else begin
        send_item(ACT_SPARE, $urandom(), $urandom(), $urandom(), $urandom());
      end
    end
    s_axis_tvalid = 1'b0;

    // drain
    wait_cnt = 0;
    while (outstanding != 0 && wait_cnt < 2000) begin
      @(negedge clk_i);
      wait_cnt++;
    end
    repeat (10) @(negedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
